// ===== src/ibp3_pkg.sv =====
// ----------------------------------------------------------------------------
// ibp3_pkg: shared types and constants
// Modulus, Barrett reduction constant and controller/datapath handshake
// structs for the integer-break product unit.
// ----------------------------------------------------------------------------
package ibp3_pkg;

    localparam int RES_W = 30;

    // prime modulus and floor(2^60 / modulus) for Barrett reduction
    localparam logic [RES_W-1:0] MODULUS    = 30'd1000000007;
    localparam logic [30:0]      BARRETT_MU = 31'd1152921496;
    localparam logic [31:0]      MODULUS_X2 = 32'd2000000014;

    // ceil(2^33 / 3): n / 3 == (n * DIV3_RECIP) >> 33 for any 32-bit n
    localparam logic [31:0]      DIV3_RECIP = 32'hAAAAAAAB;

    localparam logic [RES_W-1:0] POW_ONE    = 30'd1;
    localparam logic [RES_W-1:0] POW_BASE   = 30'd3;
    localparam logic [RES_W-1:0] SCALE_FOUR = 30'd4;
    localparam logic [RES_W-1:0] SCALE_TWO  = 30'd2;

    localparam logic [1:0] REM_ZERO = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic mul_start;
        logic mul_update;
        logic scale_start;
        logic scale_update;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic exp_zero;
        logic need_scale;
        logic acc_done;
        logic sq_done;
    } t_dp_stat;

endpackage

// ===== src/ibp3_count_if.sv =====
// ----------------------------------------------------------------------------
// ibp3_count_if: input channel
// Valid/ready channel carrying the factor count.
// ----------------------------------------------------------------------------
interface ibp3_count_if #(
    parameter int COUNT_WIDTH = 31
) ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] factor_count;

    modport source (output valid, output factor_count, input ready);
    modport sink   (input valid, input factor_count, output ready);
endinterface

// ===== src/ibp3_product_if.sv =====
// ----------------------------------------------------------------------------
// ibp3_product_if: result channel
// Valid/ready channel carrying the reduced maximal product.
// ----------------------------------------------------------------------------
interface ibp3_product_if ();
    logic                      valid;
    logic                      ready;
    logic [ibp3_pkg::RES_W-1:0] product_mod;

    modport source (output valid, output product_mod, input ready);
    modport sink   (input valid, input product_mod, output ready);
endinterface

// ===== src/ibp3_modmul.sv =====
// ----------------------------------------------------------------------------
// ibp3_modmul: modular multiplier
// Five-stage pipelined a*b mod p using Barrett reduction; result valid on
// o_done.
// ----------------------------------------------------------------------------
module ibp3_modmul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ibp3_pkg::RES_W-1:0]  i_a,
    input  logic [ibp3_pkg::RES_W-1:0]  i_b,
    output logic                        o_done,
    output logic [ibp3_pkg::RES_W-1:0]  o_result
);

    logic [4:0]  r_vld;
    logic [59:0] r_prod;
    logic [61:0] r_q2;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [31:0] r_qm;
    logic [31:0] r_rem;
    logic [ibp3_pkg::RES_W-1:0] r_res;

    logic [59:0] w_prod;
    logic [61:0] w_q2;
    logic [60:0] w_qm;
    logic [31:0] w_rem;
    logic [31:0] w_fix;

    assign w_prod = 60'(i_a) * 60'(i_b);
    assign w_q2   = 62'(r_prod[59:29]) * 62'(ibp3_pkg::BARRETT_MU);
    assign w_qm   = 61'(r_q2[61:31]) * 61'(ibp3_pkg::MODULUS);
    // true remainder is below 3p, so 32 low bits are enough
    assign w_rem  = r_p2 - r_qm;

    always_comb begin
        priority if (r_rem >= ibp3_pkg::MODULUS_X2) begin
            w_fix = r_rem - ibp3_pkg::MODULUS_X2;
        end else if (r_rem >= 32'(ibp3_pkg::MODULUS)) begin
            w_fix = r_rem - 32'(ibp3_pkg::MODULUS);
        end else begin
            w_fix = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_q2   <= w_q2;
        r_p1   <= r_prod[31:0];
        r_qm   <= w_qm[31:0];
        r_p2   <= r_p1;
        r_rem  <= w_rem;
        r_res  <= w_fix[ibp3_pkg::RES_W-1:0];
    end

    assign o_done   = r_vld[4];
    assign o_result = r_res;

endmodule

// ===== src/ibp3_datapath.sv =====
// ----------------------------------------------------------------------------
// ibp3_datapath: divide-by-three and square-and-multiply datapath
// Two-step division of n by three by reciprocal multiplication, exponent
// setup, two modular multipliers (accumulate and square) and the result
// register.
// ----------------------------------------------------------------------------
module ibp3_datapath #(
    parameter int COUNT_WIDTH = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ibp3_pkg::t_dp_cmd           i_cmd,
    output ibp3_pkg::t_dp_stat          o_stat,
    input  logic [COUNT_WIDTH-1:0]      i_count,
    output logic [ibp3_pkg::RES_W-1:0]  o_product
);

    // holds the count n, then the quotient n / 3
    logic [COUNT_WIDTH-1:0]     r_shf;
    logic [COUNT_WIDTH-1:0]     r_quot;
    logic [1:0]                 r_rem;
    logic                       r_div_cnt;
    logic [COUNT_WIDTH-1:0]     r_exp;
    logic                       r_need_scale;
    logic                       r_scale_four;
    logic [ibp3_pkg::RES_W-1:0] r_acc;
    logic [ibp3_pkg::RES_W-1:0] r_sq;
    logic [ibp3_pkg::RES_W-1:0] r_out;

    logic [63:0]                w_div_prod;
    logic [COUNT_WIDTH-1:0]     w_quot;
    logic [1:0]                 w_rem_next;
    logic [ibp3_pkg::RES_W-1:0] w_acc_b;
    logic                       w_acc_start;
    logic                       w_acc_done;
    logic                       w_sq_done;
    logic [ibp3_pkg::RES_W-1:0] w_acc_res;
    logic [ibp3_pkg::RES_W-1:0] w_sq_res;

    assign w_div_prod = 64'(r_shf) * 64'(ibp3_pkg::DIV3_RECIP);
    assign w_quot     = COUNT_WIDTH'(w_div_prod[63:33]);
    // n - 3q is below 3, so the low two bits carry it
    assign w_rem_next = r_shf[1:0] - r_quot[1:0] - {r_quot[0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shf     <= i_count;
            r_rem     <= ibp3_pkg::REM_ZERO;
            r_div_cnt <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_div_cnt) begin
                r_quot    <= w_quot;
                r_div_cnt <= 1'b1;
            end else begin
                r_shf <= r_quot;
                r_rem <= w_rem_next;
            end
        end
    end

    // exponent and final scale from quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_acc <= ibp3_pkg::POW_ONE;
            r_sq  <= ibp3_pkg::POW_BASE;
            unique case (r_rem)
                ibp3_pkg::REM_ONE: begin
                    if (r_shf == '0) begin
                        // count of one: product is 1
                        r_exp        <= '0;
                        r_need_scale <= 1'b0;
                    end else begin
                        r_exp        <= r_shf - COUNT_WIDTH'(1);
                        r_need_scale <= 1'b1;
                    end
                    r_scale_four <= 1'b1;
                end
                ibp3_pkg::REM_TWO: begin
                    r_exp        <= r_shf;
                    r_need_scale <= 1'b1;
                    r_scale_four <= 1'b0;
                end
                default: begin
                    r_exp        <= r_shf;
                    r_need_scale <= 1'b0;
                    r_scale_four <= 1'b0;
                end
            endcase
        end else if (i_cmd.mul_update) begin
            if (r_exp[0]) begin
                r_acc <= w_acc_res;
            end
            r_sq  <= w_sq_res;
            r_exp <= r_exp >> 1;
        end else if (i_cmd.scale_update) begin
            r_acc <= w_acc_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign w_acc_start = i_cmd.mul_start | i_cmd.scale_start;
    assign w_acc_b     = i_cmd.scale_start
                       ? (r_scale_four ? ibp3_pkg::SCALE_FOUR : ibp3_pkg::SCALE_TWO)
                       : r_sq;

    ibp3_modmul u_acc_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_acc_start),
        .i_a      (r_acc),
        .i_b      (w_acc_b),
        .o_done   (w_acc_done),
        .o_result (w_acc_res)
    );

    ibp3_modmul u_sq_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (r_sq),
        .i_b      (r_sq),
        .o_done   (w_sq_done),
        .o_result (w_sq_res)
    );

    assign o_stat.div_last   = r_div_cnt;
    assign o_stat.exp_zero   = (r_exp == '0);
    assign o_stat.need_scale = r_need_scale;
    assign o_stat.acc_done   = w_acc_done;
    assign o_stat.sq_done    = w_sq_done;
    assign o_product         = r_out;

endmodule

// ===== src/ibp3_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibp3_ctrl: sequencing state machine
// Steps the datapath through division, exponent loop and scaling, and owns
// the handshake flags of both channels.
// ----------------------------------------------------------------------------
module ibp3_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output ibp3_pkg::t_dp_cmd   o_cmd,
    input  ibp3_pkg::t_dp_stat  i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_LOOP;
            end
            S_LOOP: begin
                priority if (!i_stat.exp_zero) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = S_MUL;
                end else if (i_stat.need_scale) begin
                    o_cmd.scale_start = 1'b1;
                    n_state           = S_SCALE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                if (i_stat.acc_done && i_stat.sq_done) begin
                    o_cmd.mul_update = 1'b1;
                    n_state          = S_LOOP;
                end
            end
            S_SCALE: begin
                if (i_stat.acc_done) begin
                    o_cmd.scale_update = 1'b1;
                    n_state            = S_OUT;
                end
            end
            S_OUT: begin
                // wait until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/integer_break_power_of_three_mod_unit.sv =====
// ----------------------------------------------------------------------------
// integer_break_power_of_three_mod_unit: maximal integer-break product mod p
// Returns 3^q, 4*3^(q-1) or 2*3^q mod 1000000007 for a count n = 3q + r.
//
//   port       dir   beat payload
//   i_count    in    factor_count [COUNT_WIDTH-1:0]
//   o_product  out   product_mod  [29:0]
//
// One item at a time. From count beat to product valid the unit divides by
// three by reciprocal multiply, sets up the exponent, makes one pass of the
// loop and the pipelined Barrett modular multipliers per bit of the
// exponent, scales by 2 or 4 when a final scale applies, and loads the
// output register. Input is ready again the cycle after the output load.
// A finished beat waits in the output register while the next item runs;
// the next result then stalls, with the input not ready, until it drains.
// Reset is synchronous, active low; it clears the state machine and the
// output valid flag.
// ----------------------------------------------------------------------------
module integer_break_power_of_three_mod_unit #(
    parameter int COUNT_WIDTH = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ibp3_count_if.sink            i_count,
    ibp3_product_if.source        o_product
);

    ibp3_pkg::t_dp_cmd  w_cmd;
    ibp3_pkg::t_dp_stat w_stat;

    ibp3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_count.valid),
        .o_in_ready  (i_count.ready),
        .i_out_ready (o_product.ready),
        .o_out_valid (o_product.valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    ibp3_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_count   (i_count.factor_count),
        .o_product (o_product.product_mod)
    );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for integer_break_power_of_three_mod_unit
// Drives factor counts through the count channel and checks every product
// beat against a table value or an in-bench model of the 3^q / 4*3^(q-1) / 2*3^q rule mod p.
// Directed corner rows come first, then random counts. Both sides idle in
// random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int CNT_W      = 31;
    localparam int N_DIRECTED = 21;
    localparam int N_RANDOM   = 800;
    localparam int DRAIN_CYC  = 300;
    localparam int STALL_MAX  = 4000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [CNT_W-1:0]           count;
        logic                       typed;
        logic [ibp3_pkg::RES_W-1:0] want;
    } t_count_row;

    // typed rows can be read straight off the rule; the rest use the model
    localparam t_count_row DIR_ROWS [0:N_DIRECTED-1] = '{
        '{31'd0,          1'b1, 30'd1},
        '{31'd1,          1'b1, 30'd1},
        '{31'd2,          1'b1, 30'd2},
        '{31'd3,          1'b1, 30'd3},
        '{31'd4,          1'b1, 30'd4},
        '{31'd5,          1'b1, 30'd6},
        '{31'd6,          1'b1, 30'd9},
        '{31'd7,          1'b1, 30'd12},
        '{31'd8,          1'b1, 30'd18},
        '{31'd9,          1'b1, 30'd27},
        '{31'd10,         1'b1, 30'd36},
        '{31'h7FFFFFFF,   1'b0, 30'd0},
        '{31'h7FFFFFFE,   1'b0, 30'd0},
        '{31'h7FFFFFFD,   1'b0, 30'd0},
        '{31'h40000000,   1'b0, 30'd0},
        '{31'h55555555,   1'b0, 30'd0},
        '{31'h2AAAAAAA,   1'b0, 30'd0},
        '{31'd57,         1'b0, 30'd0},
        '{31'd61,         1'b0, 30'd0},
        '{31'd62,         1'b0, 30'd0},
        '{31'd96,         1'b0, 30'd0}
    };

    logic i_clk;
    logic i_rst_n;

    ibp3_count_if #(.COUNT_WIDTH(CNT_W)) cnt_if ();
    ibp3_product_if                      prod_if ();

    integer_break_power_of_three_mod_unit #(
        .COUNT_WIDTH(CNT_W)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_count   (cnt_if),
        .o_product (prod_if)
    );

    logic [ibp3_pkg::RES_W-1:0] product_q [$];
    int                         fail_cnt     = 0;
    int                         results_seen = 0;
    bit                         idle_en      = 1'b1;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [ibp3_pkg::RES_W-1:0] max_break_product(
            input logic [CNT_W-1:0] n);
        longint unsigned p;
        longint unsigned q;
        longint unsigned e;
        longint unsigned acc;
        longint unsigned sq;
        logic [1:0]      r;
        p   = longint'(ibp3_pkg::MODULUS);
        q   = longint'(n) / 3;
        r   = 2'(n % 3);
        acc = longint'(ibp3_pkg::POW_ONE);
        sq  = longint'(ibp3_pkg::POW_BASE);
        if (n == 1)
            return ibp3_pkg::POW_ONE;
        e = (r == ibp3_pkg::REM_ONE) ? q - 1 : q;
        while (e != 0) begin
            if (e[0])
                acc = (acc * sq) % p;
            sq = (sq * sq) % p;
            e  = e >> 1;
        end
        if (r == ibp3_pkg::REM_ONE)
            acc = (acc * longint'(ibp3_pkg::SCALE_FOUR)) % p;
        else if (r == ibp3_pkg::REM_TWO)
            acc = (acc * longint'(ibp3_pkg::SCALE_TWO)) % p;
        return acc[ibp3_pkg::RES_W-1:0];
    endfunction

    // Entered and left at a falling edge. The expectation is queued at the
    // rising edge where the beat is taken.
    task automatic send_count(input logic [CNT_W-1:0] n, input logic typed,
                              input logic [ibp3_pkg::RES_W-1:0] want);
        int gap;
        if (idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 8);
            cnt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cnt_if.valid        <= 1'b1;
        cnt_if.factor_count <= n;
        @(posedge i_clk);
        while (!cnt_if.ready) @(posedge i_clk);
        product_q.push_back(typed ? want : max_break_product(n));
        @(negedge i_clk);
    endtask

    function automatic logic [CNT_W-1:0] random_count();
        logic [CNT_W-1:0] n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = CNT_W'($urandom);
            4, 5, 6:    n = CNT_W'($urandom_range(0, 60));
            7:          n = 31'h7FFFFFFF - CNT_W'($urandom_range(0, 20));
            default:    n = (CNT_W'(1) << $urandom_range(0, CNT_W - 1))
                            ^ CNT_W'($urandom_range(0, 3));
        endcase
        return n;
    endfunction

    // stimulus
    initial begin
        cnt_if.valid        = 1'b0;
        cnt_if.factor_count = '0;
        i_rst_n             = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_count(DIR_ROWS[i].count, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int i = 0; i < N_RANDOM; i++) begin
            // alternate idling and quiet stretches; the tail runs flat out
            idle_en = (i < N_RANDOM - 150) && ((i / 120) % 3 != 2);
            send_count(random_count(), 1'b0, '0);
        end
        cnt_if.valid <= 1'b0;

        while (product_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("integer_break_power_of_three_mod_unit verification clean");
        else
            $display("integer_break_power_of_three_mod_unit verification failed");
        $finish;
    end

    // result side: short random stalls, plus one long hold so the block backs up
    initial begin
        int  hold_cnt;
        bit  long_done;
        hold_cnt      = 0;
        long_done     = 1'b0;
        prod_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                prod_if.ready <= 1'b0;
            end else if (!long_done && results_seen >= 40) begin
                long_done     = 1'b1;
                hold_cnt      = LONG_HOLD - 1;
                prod_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                hold_cnt      = $urandom_range(0, 7);
                prod_if.ready <= 1'b0;
            end else begin
                prod_if.ready <= 1'b1;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        logic [ibp3_pkg::RES_W-1:0] want;
        if (i_rst_n && prod_if.valid && prod_if.ready) begin
            results_seen <= results_seen + 1;
            if (product_q.size() == 0) begin
                $error("product beat with nothing expected: product_mod=%0d",
                       prod_if.product_mod);
                fail_cnt++;
            end else begin
                want = product_q.pop_front();
                if (prod_if.product_mod !== want) begin
                    $error("product_mod mismatch: expected %0d, actual %0d",
                           want, prod_if.product_mod);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        int idle_cyc;
        if (!i_rst_n || (cnt_if.valid && cnt_if.ready) ||
                (prod_if.valid && prod_if.ready)) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= STALL_MAX) begin
                $display("integer_break_power_of_three_mod_unit verification failed");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
src/ibp3_pkg.sv
src/ibp3_count_if.sv
src/ibp3_product_if.sv
src/ibp3_modmul.sv
src/ibp3_datapath.sv
src/ibp3_ctrl.sv
src/integer_break_power_of_three_mod_unit.sv
verif/tb.sv
